FILE: src/sgc_pkg.sv
// ----------------------------------------------------------------------------
// sgc_pkg - shared types and constants of the slab geometry calculator
// Field widths, register indexes, sequencer states and the structs that run
// between the sequencer, the remainder unit and the slot-count memory.
// ----------------------------------------------------------------------------
package sgc_pkg;

   // field widths fixed by the request and response formats
   localparam int SIZE_W      = 23;
   localparam int ALIGN_W     = 4;
   localparam int ORDER_W     = 4;
   localparam int SLOTS_W     = 15;
   localparam int ORDER_COUNT = 16;

   // saturating quotient: one bit above the slot field
   localparam int QSAT_W = SLOTS_W + 1;
   localparam logic [QSAT_W-1:0] QUO_SAT = QSAT_W'(1) << SLOTS_W;

   // stream payload widths, whole bytes
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_FIELD_W = 1 + SIZE_W + SIZE_W + ORDER_W + SLOTS_W + ORDER_W
                                + SLOTS_W + 1;

   // request limits
   localparam logic [SIZE_W-1:0]  SIZE_LIMIT = 23'd4194304;
   localparam logic [ALIGN_W-1:0] ALIGN_MIN  = 4'd3;
   localparam logic [ALIGN_W-1:0] ALIGN_MAX  = 4'd8;

   // default object count when the target register is zero
   localparam logic [SLOTS_W-1:0] DEFAULT_TARGET = 15'd4;

   // leftover fractions 16, 8 and 4 as shifts
   localparam int FRAC16_SHIFT = 4;
   localparam int FRAC8_SHIFT  = 3;
   localparam int FRAC4_SHIFT  = 2;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_ORDER     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREF_MAX      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_OBJECTS   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_ORDER     = 8'd3;

   localparam logic [ORDER_W-1:0] RST_MIN_ORDER   = 4'd0;
   localparam logic [ORDER_W-1:0] RST_PREF_MAX    = 4'd3;
   localparam logic [SLOTS_W-1:0] RST_MIN_OBJECTS = 15'd0;
   localparam logic [ORDER_W-1:0] RST_TOP_ORDER   = 4'd11;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_PICK  = 4'b0100,
      ST_DONE  = 4'b1000
   } seq_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   typedef struct packed {
      logic [SIZE_W-1:0] rem;
      logic [QSAT_W-1:0] quo;
   } div_stat_type;

   typedef struct packed {
      logic               en;
      logic [ORDER_W-1:0] addr;
      logic [SLOTS_W-1:0] data;
   } qmem_wr_type;

   typedef struct packed {
      logic               en;
      logic [ORDER_W-1:0] addr;
   } qmem_rd_type;

endpackage

FILE: src/slab_geometry_calculator.sv
// ----------------------------------------------------------------------------
// slab_geometry_calculator - slab page order search for one object cache
// Requests arrive on req_* (tvalid/tready/tdata); each gives an object size
// and an alignment exponent. One response per request leaves on rsp_* with
// the rounded sizes, the chosen order and slot count, the fallback order and
// slot count, a compound flag and ok. Registers are written on csr_*, which
// is always ready; write them only while no request is in flight.
// Flow: after acceptance the remainder unit sweeps the dividend
// 2^0 .. 2^(PAGE_SHIFT_BITS+15), one doubling per cycle, and fills per-order
// slot counts and leftover flags; the pick state then chooses the order and
// reads its slot count, and the final state loads the response. A zero or
// oversized size skips the sweep and goes straight to the final state.
// req_tready is high only while the sequencer is idle, so a new request is
// taken only once the last one has been handed to the output register.
// Reset (synchronous, active high) returns the registers to their defaults,
// clears the sequencer and drops rsp_tvalid. A stalled receiver holds the
// response; the sequencer waits in its final state until the output register
// frees, and a request can be accepted while the response is still held.
// ----------------------------------------------------------------------------
module slab_geometry_calculator #(
   parameter int PAGE_SHIFT_BITS = 12,
   parameter int MAX_SLOTS       = 32767
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: object_size [22:0], align_shift [26:23], zero fill above
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sgc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response: ok [0], word_size [23:1], slot_size [46:24], slab_order [50:47],
   // slab_objects [65:51], fallback_order [69:66], fallback_objects [84:70],
   // compound [85], zero fill above
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sgc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sgc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int K_LAST  = PAGE_SHIFT_BITS + sgc_pkg::ORDER_COUNT - 1;
   localparam int K_W     = $clog2(K_LAST + 1);
   localparam int BOUND_W = K_LAST;
   localparam logic [sgc_pkg::QSAT_W-1:0] MAX_Q = sgc_pkg::QSAT_W'(MAX_SLOTS);

   localparam int OW = sgc_pkg::ORDER_W;
   localparam int SW = sgc_pkg::SIZE_W;
   localparam int LW = sgc_pkg::SLOTS_W;
   localparam int QW = sgc_pkg::QSAT_W;
   localparam int NO = sgc_pkg::ORDER_COUNT;

   // ------------------------------------------------------------------ state
   sgc_pkg::seq_state_type state_ff, state_in;

   logic [OW-1:0] min_order_ff, min_order_in;
   logic [OW-1:0] pmo_ff, pmo_in;
   logic [LW-1:0] target_ff, target_in;
   logic [OW-1:0] top_order_ff, top_order_in;

   logic [SW-1:0] word_ff, word_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [K_W-1:0] k_ff, k_in;

   // captures of the sweep
   logic [QW-1:0] cap_ff, cap_in;
   logic          ovf_ff, ovf_in;
   logic [OW-1:0] g_ff, g_in;
   logic          g_hit_ff, g_hit_in;
   logic [OW-1:0] st_ff, st_in;
   logic          st_hit_ff, st_hit_in;
   logic [OW-1:0] slo_ff, slo_in;
   logic          slo_hit_ff, slo_hit_in;
   logic [OW-1:0] fb_ff, fb_in;
   logic [LW-1:0] fbobj_ff, fbobj_in;
   logic          fb_hit_ff, fb_hit_in;
   logic [NO-1:0] pass16_ff, pass16_in;
   logic [NO-1:0] pass8_ff, pass8_in;
   logic [NO-1:0] pass4_ff, pass4_in;

   logic [OW-1:0] ord_ff, ord_in;
   logic          found_ff, found_in;

   // output register
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [SW-1:0] rsp_word_ff, rsp_word_in;
   logic [SW-1:0] rsp_slot_ff, rsp_slot_in;
   logic [OW-1:0] rsp_order_ff, rsp_order_in;
   logic [LW-1:0] rsp_objs_ff, rsp_objs_in;
   logic [OW-1:0] rsp_fb_ff, rsp_fb_in;
   logic [LW-1:0] rsp_fbobj_ff, rsp_fbobj_in;
   logic          rsp_comp_ff, rsp_comp_in;

   // ----------------------------------------------------------- submodules
   sgc_pkg::div_ctrl_type div_ctrl;
   sgc_pkg::div_stat_type div_stat;
   sgc_pkg::qmem_wr_type  qmem_wr;
   sgc_pkg::qmem_rd_type  qmem_rd;
   logic [LW-1:0]         qmem_data;

   sgc_div_unit u_div (
      .clock   (clock),
      .divisor (slot_ff),
      .ctrl    (div_ctrl),
      .stat    (div_stat)
   );

   sgc_qmem u_qmem (
      .clock   (clock),
      .wr      (qmem_wr),
      .rd      (qmem_rd),
      .rd_data (qmem_data)
   );

   // ------------------------------------------------------- request decode
   logic [SW-1:0]      req_size;
   logic [sgc_pkg::ALIGN_W-1:0] req_shift, shift_clamp;
   logic [SW:0]        word_wide, align_mask, slot_wide;
   logic               req_bad;
   logic               req_accept;

   assign req_size   = req_tdata[SW-1:0];
   assign req_shift  = req_tdata[SW +: sgc_pkg::ALIGN_W];
   assign req_accept = req_tvalid && req_tready;
   assign req_bad    = (req_size == '0) || (req_size > sgc_pkg::SIZE_LIMIT);

   always_comb begin
      shift_clamp = req_shift;
      if (req_shift < sgc_pkg::ALIGN_MIN) begin
         shift_clamp = sgc_pkg::ALIGN_MIN;
      end else if (req_shift > sgc_pkg::ALIGN_MAX) begin
         shift_clamp = sgc_pkg::ALIGN_MAX;
      end
   end

   // round up to 8 bytes, then to the alignment
   assign word_wide  = ({1'b0, req_size} + (SW + 1)'(7)) & ~((SW + 1)'(7));
   assign align_mask = ((SW + 1)'(1) << shift_clamp) - (SW + 1)'(1);
   assign slot_wide  = (word_wide + align_mask) & ~align_mask;

   // ------------------------------------------------------- sweep evaluate
   logic          eval;
   logic [OW-1:0] sweep_order;
   logic [K_W-1:0] k_rel;
   logic [LW-1:0] quo_sat;
   logic [LW-1:0] tgt;
   logic [BOUND_W-1:0] rem_wide, bound16, bound8, bound4;

   assign tgt         = (target_ff == '0) ? sgc_pkg::DEFAULT_TARGET : target_ff;
   assign eval        = k_ff >= K_W'(PAGE_SHIFT_BITS);
   assign k_rel       = k_ff - K_W'(PAGE_SHIFT_BITS);
   assign sweep_order = k_rel[OW-1:0];
   assign quo_sat     = (div_stat.quo > MAX_Q) ? MAX_Q[LW-1:0] : div_stat.quo[LW-1:0];
   assign rem_wide    = BOUND_W'(div_stat.rem);
   // leftover limits slab / 16, slab / 8, slab / 4 of the order under test
   assign bound16     = BOUND_W'(1) << (k_ff - K_W'(sgc_pkg::FRAC16_SHIFT));
   assign bound8      = BOUND_W'(1) << (k_ff - K_W'(sgc_pkg::FRAC8_SHIFT));
   assign bound4      = BOUND_W'(1) << (k_ff - K_W'(sgc_pkg::FRAC4_SHIFT));

   // --------------------------------------------------------- order pick
   function automatic logic [OW-1:0] lowest_set(input logic [NO-1:0] v);
      logic [OW-1:0] res;
      res = '0;
      for (int i = NO - 1; i >= 0; i--) begin
         if (v[i]) res = OW'(i);
      end
      return res;
   endfunction

   function automatic logic [OW-1:0] highest_set(input logic [NO-1:0] v);
      logic [OW-1:0] res;
      res = '0;
      for (int i = 0; i < NO; i++) begin
         if (v[i]) res = OW'(i);
      end
      return res;
   endfunction

   logic [OW-1:0] shi_raw, shi, slo, lr, g_m1;
   logic          run_loop;
   logic [NO-1:0] top_mask, scan_mask, m16, m8, m4, msc;
   logic          pick_found;
   logic [OW-1:0] pick_ord;

   // count target capped by the slots at the preferred order; the start
   // order of a count c is the first order holding c slots
   assign run_loop = (tgt >= LW'(2)) && (cap_ff >= QW'(2));
   assign shi_raw  = (QW'(tgt) <= cap_ff) ? st_ff : pmo_ff;
   assign shi      = (shi_raw > min_order_ff) ? shi_raw : min_order_ff;
   assign slo      = (slo_ff > min_order_ff) ? slo_ff : min_order_ff;
   assign lr       = (fb_ff > min_order_ff) ? fb_ff : min_order_ff;
   assign g_m1     = g_ff - OW'(1);

   always_comb begin
      for (int i = 0; i < NO; i++) begin
         top_mask[i]  = (OW'(i) >= shi) && (OW'(i) <= pmo_ff);
         scan_mask[i] = (OW'(i) >= slo) && (OW'(i) <= pmo_ff) && (OW'(i) < shi);
      end
   end

   assign m16 = pass16_ff & top_mask;
   assign m8  = pass8_ff & top_mask;
   assign m4  = pass4_ff & top_mask;
   assign msc = pass4_ff & scan_mask;

   always_comb begin
      pick_found = 1'b0;
      pick_ord   = '0;
      if (ovf_ff) begin
         // too many slots at the lowest order: every try gives the order
         // below the one holding MAX_SLOTS slots
         if (g_ff != '0) begin
            if ((run_loop && (g_m1 <= pmo_ff)) || (g_m1 < top_order_ff)) begin
               pick_found = 1'b1;
               pick_ord   = g_m1;
            end
         end
      end else if (run_loop && (m16 != '0)) begin
         pick_found = 1'b1;
         pick_ord   = lowest_set(m16);
      end else if (run_loop && (m8 != '0)) begin
         pick_found = 1'b1;
         pick_ord   = lowest_set(m8);
      end else if (run_loop && (m4 != '0)) begin
         pick_found = 1'b1;
         pick_ord   = lowest_set(m4);
      end else if (run_loop && (msc != '0)) begin
         // smaller counts start lower: the first hit walking down wins
         pick_found = 1'b1;
         pick_ord   = highest_set(msc);
      end else if (lr < top_order_ff) begin
         // last resort: smallest order holding one slot
         pick_found = 1'b1;
         pick_ord   = lr;
      end
   end

   // ------------------------------------------------------------ sequencer
   logic rsp_free;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      min_order_in  = min_order_ff;
      pmo_in        = pmo_ff;
      target_in     = target_ff;
      top_order_in  = top_order_ff;
      word_in       = word_ff;
      slot_in       = slot_ff;
      k_in          = k_ff;
      cap_in        = cap_ff;
      ovf_in        = ovf_ff;
      g_in          = g_ff;
      g_hit_in      = g_hit_ff;
      st_in         = st_ff;
      st_hit_in     = st_hit_ff;
      slo_in        = slo_ff;
      slo_hit_in    = slo_hit_ff;
      fb_in         = fb_ff;
      fbobj_in      = fbobj_ff;
      fb_hit_in     = fb_hit_ff;
      pass16_in     = pass16_ff;
      pass8_in      = pass8_ff;
      pass4_in      = pass4_ff;
      ord_in        = ord_ff;
      found_in      = found_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_objs_in   = rsp_objs_ff;
      rsp_fb_in     = rsp_fb_ff;
      rsp_fbobj_in  = rsp_fbobj_ff;
      rsp_comp_in   = rsp_comp_ff;
      div_ctrl      = '0;
      qmem_wr       = '0;
      qmem_rd       = '0;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sgc_pkg::CSR_MIN_ORDER:   min_order_in = csr_data[OW-1:0];
            sgc_pkg::CSR_PREF_MAX:    pmo_in       = csr_data[OW-1:0];
            sgc_pkg::CSR_MIN_OBJECTS: target_in    = csr_data[LW-1:0];
            sgc_pkg::CSR_TOP_ORDER:   top_order_in = csr_data[OW-1:0];
            default: ;
         endcase
      end

      // drop the response once taken
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         sgc_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_bad) begin
                  word_in  = '0;
                  slot_in  = '0;
                  found_in = 1'b0;
                  state_in = sgc_pkg::ST_DONE;
               end else begin
                  word_in       = word_wide[SW-1:0];
                  slot_in       = slot_wide[SW-1:0];
                  k_in          = '0;
                  g_hit_in      = 1'b0;
                  st_hit_in     = 1'b0;
                  slo_hit_in    = 1'b0;
                  fb_hit_in     = 1'b0;
                  pass16_in     = '0;
                  pass8_in      = '0;
                  pass4_in      = '0;
                  div_ctrl.load = 1'b1;
                  state_in      = sgc_pkg::ST_SWEEP;
               end
            end
         end
         sgc_pkg::ST_SWEEP: begin
            div_ctrl.step = 1'b1;
            if (eval) begin
               qmem_wr.en   = 1'b1;
               qmem_wr.addr = sweep_order;
               qmem_wr.data = quo_sat;
               if (sweep_order == pmo_ff) cap_in = div_stat.quo;
               if (sweep_order == min_order_ff) ovf_in = div_stat.quo > MAX_Q;
               if (!g_hit_ff && (div_stat.quo >= MAX_Q)) begin
                  g_in     = sweep_order;
                  g_hit_in = 1'b1;
               end
               if (!st_hit_ff && (div_stat.quo >= QW'(tgt))) begin
                  st_in     = sweep_order;
                  st_hit_in = 1'b1;
               end
               if (!slo_hit_ff && (div_stat.quo >= QW'(2))) begin
                  slo_in     = sweep_order;
                  slo_hit_in = 1'b1;
               end
               if (!fb_hit_ff && (div_stat.quo != '0)) begin
                  fb_in     = sweep_order;
                  fbobj_in  = quo_sat;
                  fb_hit_in = 1'b1;
               end
               pass16_in[sweep_order] = rem_wide <= bound16;
               pass8_in[sweep_order]  = rem_wide <= bound8;
               pass4_in[sweep_order]  = rem_wide <= bound4;
            end
            k_in = k_ff + K_W'(1);
            if (k_ff == K_W'(K_LAST)) begin
               state_in = sgc_pkg::ST_PICK;
            end
         end
         sgc_pkg::ST_PICK: begin
            found_in     = pick_found;
            ord_in       = pick_ord;
            qmem_rd.en   = 1'b1;
            qmem_rd.addr = pick_ord;
            state_in     = sgc_pkg::ST_DONE;
         end
         sgc_pkg::ST_DONE: begin
            // hold here until the output register frees
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_ok_in     = found_ff && (qmem_data != '0);
               rsp_word_in   = word_ff;
               rsp_slot_in   = slot_ff;
               rsp_order_in  = found_ff ? ord_ff : '0;
               rsp_objs_in   = found_ff ? qmem_data : '0;
               rsp_fb_in     = found_ff ? fb_ff : '0;
               rsp_fbobj_in  = found_ff ? fbobj_ff : '0;
               rsp_comp_in   = found_ff && (ord_ff != '0);
               state_in      = sgc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgc_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sgc_pkg::ST_IDLE;
         min_order_ff  <= sgc_pkg::RST_MIN_ORDER;
         pmo_ff        <= sgc_pkg::RST_PREF_MAX;
         target_ff     <= sgc_pkg::RST_MIN_OBJECTS;
         top_order_ff  <= sgc_pkg::RST_TOP_ORDER;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_order_ff  <= min_order_in;
         pmo_ff        <= pmo_in;
         target_ff     <= target_in;
         top_order_ff  <= top_order_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      slot_ff      <= slot_in;
      k_ff         <= k_in;
      cap_ff       <= cap_in;
      ovf_ff       <= ovf_in;
      g_ff         <= g_in;
      g_hit_ff     <= g_hit_in;
      st_ff        <= st_in;
      st_hit_ff    <= st_hit_in;
      slo_ff       <= slo_in;
      slo_hit_ff   <= slo_hit_in;
      fb_ff        <= fb_in;
      fbobj_ff     <= fbobj_in;
      fb_hit_ff    <= fb_hit_in;
      pass16_ff    <= pass16_in;
      pass8_ff     <= pass8_in;
      pass4_ff     <= pass4_in;
      ord_ff       <= ord_in;
      found_ff     <= found_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_order_ff <= rsp_order_in;
      rsp_objs_ff  <= rsp_objs_in;
      rsp_fb_ff    <= rsp_fb_in;
      rsp_fbobj_ff <= rsp_fbobj_in;
      rsp_comp_ff  <= rsp_comp_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_tready = (state_ff == sgc_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(sgc_pkg::RSP_DATA_W - sgc_pkg::RSP_FIELD_W)'(0),
                        rsp_comp_ff, rsp_fbobj_ff, rsp_fb_ff, rsp_objs_ff,
                        rsp_order_ff, rsp_slot_ff, rsp_word_ff, rsp_ok_ff};

   // ----------------------------------------------------------- assertions
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == sgc_pkg::ST_SWEEP) || (state_ff == sgc_pkg::ST_DONE))
      else $error("accepted request did not start a sweep or a response");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgc_pkg::ST_SWEEP) |-> (k_ff <= K_W'(K_LAST)))
      else $error("sweep counter ran past the last order");

   a_ok_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_ok_ff) |-> ((rsp_fbobj_ff != '0) && (rsp_slot_ff != '0)))
      else $error("ok response without fallback slots or slot size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == sgc_pkg::ST_DONE))
      else $error("response raised outside the final state");

endmodule

FILE: src/sgc_div_unit.sv
// ----------------------------------------------------------------------------
// sgc_div_unit - power-of-two remainder and quotient unit
// Each step doubles the dividend: one compare and subtract against the slot
// size yields 2^k mod size and a saturating floor(2^k / size).
// ----------------------------------------------------------------------------
module sgc_div_unit (
   input  logic                       clock,
   input  logic [sgc_pkg::SIZE_W-1:0] divisor,
   input  sgc_pkg::div_ctrl_type      ctrl,
   output sgc_pkg::div_stat_type      stat
);

   logic [sgc_pkg::SIZE_W-1:0] rem_ff, rem_in;
   logic [sgc_pkg::QSAT_W-1:0] quo_ff, quo_in;
   logic [sgc_pkg::SIZE_W:0]   dbl;
   logic                       ge;
   logic [sgc_pkg::QSAT_W-1:0] quo_sum;

   assign dbl     = {rem_ff, 1'b0};
   assign ge      = dbl >= {1'b0, divisor};
   assign quo_sum = {quo_ff[sgc_pkg::QSAT_W-2:0], ge};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         // dividend 2^0
         rem_in = sgc_pkg::SIZE_W'(1);
         quo_in = '0;
      end else if (ctrl.step) begin
         rem_in = ge ? sgc_pkg::SIZE_W'(dbl - {1'b0, divisor}) : dbl[sgc_pkg::SIZE_W-1:0];
         // stick at the saturation value once reached
         if (quo_ff[sgc_pkg::QSAT_W-1] || quo_sum[sgc_pkg::QSAT_W-1]) begin
            quo_in = sgc_pkg::QUO_SAT;
         end else begin
            quo_in = quo_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.rem = rem_ff;
   assign stat.quo = quo_ff;

endmodule

FILE: src/sgc_qmem.sv
// ----------------------------------------------------------------------------
// sgc_qmem - slot count per page order
// One write and one registered read per cycle, one entry per order.
// ----------------------------------------------------------------------------
module sgc_qmem (
   input  logic                        clock,
   input  sgc_pkg::qmem_wr_type        wr,
   input  sgc_pkg::qmem_rd_type        rd,
   output logic [sgc_pkg::SLOTS_W-1:0] rd_data
);

   logic [sgc_pkg::SLOTS_W-1:0] mem_ff [sgc_pkg::ORDER_COUNT];
   logic [sgc_pkg::SLOTS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
